### rtl/core/mos6502_alu_register_execute_top_defines.svh
// Assertion macros shared by the 6502 ALU execute block.
`ifndef MOS6502_ALU_REGISTER_EXECUTE_TOP_DEFINES_SVH
`define MOS6502_ALU_REGISTER_EXECUTE_TOP_DEFINES_SVH

// Plain clocked assertion, disabled while reset is high.
`define M6502_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication: when the antecedent holds, the consequent holds in the next cycle.
`define M6502_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/m6502alu_pkg.sv
// Package with operation codes, flag positions and helpers for the 6502 ALU block.
package m6502alu_pkg;

   // Operation codes, mnemonic order
   typedef enum logic [5:0] {
      OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,  OP_BCS = 6'd4,
      OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,  OP_BNE = 6'd8,  OP_BPL = 6'd9,
      OP_BVC = 6'd10, OP_BVS = 6'd11, OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14,
      OP_CLV = 6'd15, OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
      OP_EOR = 6'd20, OP_INC = 6'd21, OP_LDA = 6'd22, OP_LDX = 6'd23, OP_LDY = 6'd24,
      OP_LSR = 6'd25, OP_NOP = 6'd26, OP_ORA = 6'd27, OP_PHA = 6'd28, OP_PHP = 6'd29,
      OP_PLA = 6'd30, OP_PLP = 6'd31, OP_ROL = 6'd32, OP_ROR = 6'd33, OP_SBC = 6'd34,
      OP_SEC = 6'd35, OP_SED = 6'd36, OP_SEI = 6'd37, OP_STA = 6'd38, OP_STX = 6'd39,
      OP_STY = 6'd40, OP_TAX = 6'd41, OP_TAY = 6'd42, OP_TSX = 6'd43, OP_TXA = 6'd44,
      OP_TXS = 6'd45, OP_TYA = 6'd46
   } func_type;

   // Read-modify-write destinations
   typedef enum logic [1:0] {
      TGT_MEM = 2'd0,
      TGT_A   = 2'd1,
      TGT_X   = 2'd2,
      TGT_Y   = 2'd3
   } target_type;

   // Status bit positions, NV-BDIZC
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_1 = 5;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0] RESET_S = 8'hFD;
   localparam logic [7:0] RESET_P = 8'h24;
   localparam logic       STACK_PAGE = 1'b1;

   // One result item
   typedef struct packed {
      logic       unknown_op;
      logic       branch_taken;
      logic [7:0] out_p;
      logic [7:0] out_s;
      logic [7:0] out_y;
      logic [7:0] out_x;
      logic [7:0] out_a;
      logic [8:0] stack_addr;
      logic       mem_write;
      logic [7:0] mem_data;
   } rsp_type;

   // Update N and Z from a result byte
   function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] q;
      q = p;
      q[FLAG_N] = v[7];
      q[FLAG_Z] = (v == 8'h00);
      return q;
   endfunction

endpackage

### rtl/core/mos6502_alu_register_execute_top.sv
// Top level of the 6502 ALU and register execute block.
//
// Usage: each request on the req_ channel carries one 6502 operation (func),
// a read-modify-write destination (target) and an already fetched operand
// byte. The block applies the operation to its A, X, Y, S and P registers and
// returns one response on the rsp_ channel with the memory write request, the
// page one stack address and the register file after the operation.
// Path: a request waits in the input register and is then executed into the
// result register, which holds its response until the response is taken.
// Throughput: one request per cycle while the receiver takes responses; each
// operation is combinational 8-bit logic (add, logic, shift or transfer) and
// a flag update between the input register and the result register.
// Reset (synchronous, active high) sets A=X=Y=0, S=0xFD, P=0x24 and empties
// both pipeline registers. When the receiver stalls, the result register
// holds its response; the input register can still take one more request,
// after which req_tready drops until the response is taken. Register state
// advances only when an operation moves into the result register, so a
// stall never loses or repeats an operation.
`include "mos6502_alu_register_execute_top_defines.svh"

module mos6502_alu_register_execute_top
   import m6502alu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [5:0] func, [7:6] target, [15:8] operand
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [7:0] mem_data, [8] mem_write, [17:9] stack_addr,
                                    // [25:18] out_a, [33:26] out_x, [41:34] out_y,
                                    // [49:42] out_s, [57:50] out_p, [58] branch_taken,
                                    // [59] unknown_op, [63:60] zero
);

   // Input register
   logic       in_valid_ff;
   logic [5:0] in_func_ff;
   logic [1:0] in_target_ff;
   logic [7:0] in_operand_ff;

   // Architectural registers
   logic [7:0] reg_a_ff, reg_x_ff, reg_y_ff, reg_s_ff, reg_p_ff;
   logic [7:0] reg_a_in, reg_x_in, reg_y_in, reg_s_in, reg_p_in;

   // Result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic       exec_fire;
   logic       req_fire;
   func_type   func;
   target_type target;
   logic [7:0] cur;
   logic [7:0] addend;
   logic [8:0] sum;
   logic [7:0] rmw_res;
   logic       rmw_carry;
   logic       is_rmw;
   logic       is_branch;
   logic       wr;
   logic [7:0] wdata;
   logic       stk;
   logic [8:0] saddr;
   logic       taken;
   logic       unk;

   // Execute when an operation is waiting and the result register is empty or being taken
   assign exec_fire  = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || exec_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_func_ff    <= req_tdata[5:0];
         in_target_ff  <= req_tdata[7:6];
         in_operand_ff <= req_tdata[15:8];
      end
   end

   assign func   = func_type'(in_func_ff);
   assign target = target_type'(in_target_ff);

   // Operand of shift, rotate, INC and DEC
   always_comb begin
      case (target)
         TGT_A:   cur = reg_a_ff;
         TGT_X:   cur = reg_x_ff;
         TGT_Y:   cur = reg_y_ff;
         default: cur = in_operand_ff;
      endcase
   end

   // Binary adder shared by ADC and SBC
   assign addend = (func == OP_SBC) ? ~in_operand_ff : in_operand_ff;
   assign sum    = {1'b0, reg_a_ff} + {1'b0, addend} + {8'h00, reg_p_ff[FLAG_C]};

   // Operation decode and register update
   always_comb begin
      reg_a_in  = reg_a_ff;
      reg_x_in  = reg_x_ff;
      reg_y_in  = reg_y_ff;
      reg_s_in  = reg_s_ff;
      reg_p_in  = reg_p_ff;
      rmw_res   = 8'h00;
      rmw_carry = 1'b0;
      is_rmw    = 1'b0;
      is_branch = 1'b0;
      wr        = 1'b0;
      wdata     = 8'h00;
      stk       = 1'b0;
      saddr     = {STACK_PAGE, reg_s_ff};
      taken     = 1'b0;
      unk       = 1'b0;
      case (func)
         OP_ADC, OP_SBC: begin
            reg_a_in = sum[7:0];
            reg_p_in = set_nz(reg_p_ff, sum[7:0]);
            reg_p_in[FLAG_C] = sum[8];
            reg_p_in[FLAG_V] = ~(reg_a_ff[7] ^ addend[7]) & (reg_a_ff[7] ^ sum[7]);
         end
         OP_AND: begin
            reg_a_in = reg_a_ff & in_operand_ff;
            reg_p_in = set_nz(reg_p_ff, reg_a_in);
         end
         OP_EOR: begin
            reg_a_in = reg_a_ff ^ in_operand_ff;
            reg_p_in = set_nz(reg_p_ff, reg_a_in);
         end
         OP_ORA: begin
            reg_a_in = reg_a_ff | in_operand_ff;
            reg_p_in = set_nz(reg_p_ff, reg_a_in);
         end
         OP_ASL: begin
            is_rmw = 1'b1; rmw_carry = cur[7]; rmw_res = {cur[6:0], 1'b0};
         end
         OP_LSR: begin
            is_rmw = 1'b1; rmw_carry = cur[0]; rmw_res = {1'b0, cur[7:1]};
         end
         OP_ROL: begin
            is_rmw = 1'b1; rmw_carry = cur[7]; rmw_res = {cur[6:0], reg_p_ff[FLAG_C]};
         end
         OP_ROR: begin
            is_rmw = 1'b1; rmw_carry = cur[0]; rmw_res = {reg_p_ff[FLAG_C], cur[7:1]};
         end
         OP_INC: begin
            is_rmw = 1'b1; rmw_carry = reg_p_ff[FLAG_C]; rmw_res = cur + 8'h01;
         end
         OP_DEC: begin
            is_rmw = 1'b1; rmw_carry = reg_p_ff[FLAG_C]; rmw_res = cur - 8'h01;
         end
         OP_BCC: begin is_branch = 1'b1; taken = !reg_p_ff[FLAG_C]; end
         OP_BCS: begin is_branch = 1'b1; taken =  reg_p_ff[FLAG_C]; end
         OP_BEQ: begin is_branch = 1'b1; taken =  reg_p_ff[FLAG_Z]; end
         OP_BNE: begin is_branch = 1'b1; taken = !reg_p_ff[FLAG_Z]; end
         OP_BMI: begin is_branch = 1'b1; taken =  reg_p_ff[FLAG_N]; end
         OP_BPL: begin is_branch = 1'b1; taken = !reg_p_ff[FLAG_N]; end
         OP_BVC: begin is_branch = 1'b1; taken = !reg_p_ff[FLAG_V]; end
         OP_BVS: begin is_branch = 1'b1; taken =  reg_p_ff[FLAG_V]; end
         OP_BIT: begin
            reg_p_in[FLAG_N] = in_operand_ff[7];
            reg_p_in[FLAG_V] = in_operand_ff[6];
            reg_p_in[FLAG_Z] = ((in_operand_ff & reg_a_ff) == 8'h00);
         end
         OP_CLC: reg_p_in[FLAG_C] = 1'b0;
         OP_CLD: reg_p_in[FLAG_D] = 1'b0;
         OP_CLI: reg_p_in[FLAG_I] = 1'b0;
         OP_CLV: reg_p_in[FLAG_V] = 1'b0;
         OP_SEC: reg_p_in[FLAG_C] = 1'b1;
         OP_SED: reg_p_in[FLAG_D] = 1'b1;
         OP_SEI: reg_p_in[FLAG_I] = 1'b1;
         OP_CMP, OP_CPX, OP_CPY: begin
            // compare register against operand: C is "no borrow"
            case (func)
               OP_CPX:  wdata = reg_x_ff;
               OP_CPY:  wdata = reg_y_ff;
               default: wdata = reg_a_ff;
            endcase
            reg_p_in = set_nz(reg_p_ff, wdata - in_operand_ff);
            reg_p_in[FLAG_C] = (wdata >= in_operand_ff);
            wdata = 8'h00;
         end
         OP_LDA: begin reg_a_in = in_operand_ff; reg_p_in = set_nz(reg_p_ff, in_operand_ff); end
         OP_LDX: begin reg_x_in = in_operand_ff; reg_p_in = set_nz(reg_p_ff, in_operand_ff); end
         OP_LDY: begin reg_y_in = in_operand_ff; reg_p_in = set_nz(reg_p_ff, in_operand_ff); end
         OP_NOP: ;
         OP_PHA, OP_PHP: begin
            // push at S, then decrement
            stk      = 1'b1;
            wr       = 1'b1;
            saddr    = {STACK_PAGE, reg_s_ff};
            wdata    = (func == OP_PHA) ? reg_a_ff : (reg_p_ff | 8'h30);
            reg_s_in = reg_s_ff - 8'h01;
         end
         OP_PLA: begin
            stk      = 1'b1;
            reg_s_in = reg_s_ff + 8'h01;
            saddr    = {STACK_PAGE, reg_s_in};
            reg_a_in = in_operand_ff;
            reg_p_in = set_nz(reg_p_ff, in_operand_ff);
         end
         OP_PLP: begin
            stk      = 1'b1;
            reg_s_in = reg_s_ff + 8'h01;
            saddr    = {STACK_PAGE, reg_s_in};
            reg_p_in = in_operand_ff;
            reg_p_in[FLAG_B] = 1'b0;
            reg_p_in[FLAG_1] = 1'b1;
         end
         OP_STA: begin wr = 1'b1; wdata = reg_a_ff; end
         OP_STX: begin wr = 1'b1; wdata = reg_x_ff; end
         OP_STY: begin wr = 1'b1; wdata = reg_y_ff; end
         OP_TAX: begin reg_x_in = reg_a_ff; reg_p_in = set_nz(reg_p_ff, reg_a_ff); end
         OP_TAY: begin reg_y_in = reg_a_ff; reg_p_in = set_nz(reg_p_ff, reg_a_ff); end
         OP_TSX: begin reg_x_in = reg_s_ff; reg_p_in = set_nz(reg_p_ff, reg_s_ff); end
         OP_TXA: begin reg_a_in = reg_x_ff; reg_p_in = set_nz(reg_p_ff, reg_x_ff); end
         OP_TXS: reg_s_in = reg_x_ff;
         OP_TYA: begin reg_a_in = reg_y_ff; reg_p_in = set_nz(reg_p_ff, reg_y_ff); end
         default: unk = 1'b1;
      endcase

      // Route the read-modify-write result
      if (is_rmw) begin
         reg_p_in = set_nz(reg_p_ff, rmw_res);
         reg_p_in[FLAG_C] = rmw_carry;
         case (target)
            TGT_A:   reg_a_in = rmw_res;
            TGT_X:   reg_x_in = rmw_res;
            TGT_Y:   reg_y_in = rmw_res;
            default: begin wr = 1'b1; wdata = rmw_res; end
         endcase
      end

      // Stack address: S after the step unless a push or pull used it
      if (!stk) begin
         saddr = {STACK_PAGE, reg_s_in};
      end
   end

   always_comb begin
      rsp_in.mem_data     = wr ? wdata : 8'h00;
      rsp_in.mem_write    = wr;
      rsp_in.stack_addr   = saddr;
      rsp_in.out_a        = reg_a_in;
      rsp_in.out_x        = reg_x_in;
      rsp_in.out_y        = reg_y_in;
      rsp_in.out_s        = reg_s_in;
      rsp_in.out_p        = reg_p_in;
      rsp_in.branch_taken = taken;
      rsp_in.unknown_op   = unk;
   end

   // Advance architectural state only when the operation moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         reg_a_ff <= 8'h00;
         reg_x_ff <= 8'h00;
         reg_y_ff <= 8'h00;
         reg_s_ff <= RESET_S;
         reg_p_ff <= RESET_P;
      end else if (exec_fire) begin
         reg_a_ff <= reg_a_in;
         reg_x_ff <= reg_x_in;
         reg_y_ff <= reg_y_in;
         reg_s_ff <= reg_s_in;
         reg_p_ff <= reg_p_in;
      end
   end

   // Result register: hold while the receiver stalls, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_ff};

   // Assertions
   `M6502_ASSERT(a_p_bit5_set, clock, reset, reg_p_ff[FLAG_1] && !reg_p_ff[FLAG_B],
      "status register bit 5 must be set and B clear")
   `M6502_ASSERT(a_rsp_matches_state, clock, reset,
      !rsp_valid_ff || (rsp_ff.out_a == reg_a_ff && rsp_ff.out_s == reg_s_ff
                        && rsp_ff.out_p == reg_p_ff),
      "pending response must match register state")
   `M6502_ASSERT_NEXT(a_unknown_no_change, clock, reset, exec_fire && unk,
      $stable(reg_a_ff) && $stable(reg_x_ff) && $stable(reg_y_ff)
      && $stable(reg_s_ff) && $stable(reg_p_ff),
      "unknown operation must not change state")
   `M6502_ASSERT(a_taken_only_branch, clock, reset, !exec_fire || !taken || is_branch,
      "branch taken reported for non-branch operation")
   `M6502_ASSERT(a_no_write_zero_data, clock, reset,
      !rsp_valid_ff || rsp_ff.mem_write || rsp_ff.mem_data == 8'h00,
      "write data must be zero without a write")

endmodule

### tb/tb_mos6502_alu_register_execute_top.sv
// Self-checking testbench for the 6502 ALU and register execute block.
`timescale 1ns / 1ps

module tb_mos6502_alu_register_execute_top;
   import m6502alu_pkg::*;

   localparam int NUM_RANDOM     = 1600;
   localparam int IDLE_PERCENT   = 22;
   localparam int CALM_FIRST     = 600;    // random requests [CALM_FIRST, CALM_LAST) never idle
   localparam int CALM_LAST      = 1000;
   localparam int DRAIN_AT       = 800;    // hold the sender here until all responses are back
   localparam int PIPE_CYCLES    = 10;     // settle time after the last response
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int FIRST_UNKNOWN  = int'(OP_TYA) + 1;
   localparam int LAST_UNKNOWN   = 63;

   // Shadow copy of the register file; predicts one response per request
   class exec_shadow;
      logic [7:0] a, x, y, s, p;
      rsp_type    expected_rsp[$];
      int         errors;

      function new();
         a = 8'h00;
         x = 8'h00;
         y = 8'h00;
         s = RESET_S;
         p = RESET_P;
         errors = 0;
      endfunction

      function logic [7:0] nz(logic [7:0] v);
         p[FLAG_N] = v[7];
         p[FLAG_Z] = (v == 8'h00);
         return v;
      endfunction

      function logic [7:0] add_carry(logic [7:0] l, logic [7:0] r);
         logic [8:0] sum;
         sum = {1'b0, l} + {1'b0, r} + {8'h00, p[FLAG_C]};
         p[FLAG_C] = sum[8];
         p[FLAG_V] = ~(l[7] ^ r[7]) & (l[7] ^ sum[7]);
         return nz(sum[7:0]);
      endfunction

      function void compare_with(logic [7:0] r, logic [7:0] v);
         logic [7:0] diff;
         diff = r - v;
         p[FLAG_C] = (r >= v);
         void'(nz(diff));
      endfunction

      // Execute one accepted request and queue the response it must produce
      function void note_request(logic [15:0] data);
         logic [5:0] func;
         target_type tgt;
         logic [7:0] opnd, cur, res, wdata;
         logic       cin, wr, stk, taken, unk, rmw;
         logic [8:0] saddr;
         rsp_type    r;
         func  = data[5:0];
         tgt   = target_type'(data[7:6]);
         opnd  = data[15:8];
         res   = 8'h00;
         wdata = 8'h00;
         saddr = 9'h000;
         {wr, stk, taken, unk, rmw} = 5'b00000;
         cin   = p[FLAG_C];
         case (tgt)
            TGT_A:   cur = a;
            TGT_X:   cur = x;
            TGT_Y:   cur = y;
            default: cur = opnd;
         endcase

         case (func)
            OP_ADC: a = add_carry(a, opnd);
            OP_SBC: a = add_carry(a, ~opnd);
            OP_AND: a = nz(a & opnd);
            OP_EOR: a = nz(a ^ opnd);
            OP_ORA: a = nz(a | opnd);
            OP_BIT: begin
               p[FLAG_N] = opnd[7];
               p[FLAG_V] = opnd[6];
               p[FLAG_Z] = ((opnd & a) == 8'h00);
            end
            OP_BCC: taken = !p[FLAG_C];
            OP_BCS: taken =  p[FLAG_C];
            OP_BEQ: taken =  p[FLAG_Z];
            OP_BNE: taken = !p[FLAG_Z];
            OP_BMI: taken =  p[FLAG_N];
            OP_BPL: taken = !p[FLAG_N];
            OP_BVC: taken = !p[FLAG_V];
            OP_BVS: taken =  p[FLAG_V];
            OP_CLC: p[FLAG_C] = 1'b0;
            OP_CLD: p[FLAG_D] = 1'b0;
            OP_CLI: p[FLAG_I] = 1'b0;
            OP_CLV: p[FLAG_V] = 1'b0;
            OP_SEC: p[FLAG_C] = 1'b1;
            OP_SED: p[FLAG_D] = 1'b1;
            OP_SEI: p[FLAG_I] = 1'b1;
            OP_CMP: compare_with(a, opnd);
            OP_CPX: compare_with(x, opnd);
            OP_CPY: compare_with(y, opnd);
            OP_ASL: begin
               p[FLAG_C] = cur[7];
               res = nz({cur[6:0], 1'b0});
               rmw = 1'b1;
            end
            OP_LSR: begin
               p[FLAG_C] = cur[0];
               res = nz({1'b0, cur[7:1]});
               rmw = 1'b1;
            end
            OP_ROL: begin
               p[FLAG_C] = cur[7];
               res = nz({cur[6:0], cin});
               rmw = 1'b1;
            end
            OP_ROR: begin
               p[FLAG_C] = cur[0];
               res = nz({cin, cur[7:1]});
               rmw = 1'b1;
            end
            OP_INC: begin
               res = nz(cur + 8'h01);
               rmw = 1'b1;
            end
            OP_DEC: begin
               res = nz(cur - 8'h01);
               rmw = 1'b1;
            end
            OP_LDA: a = nz(opnd);
            OP_LDX: x = nz(opnd);
            OP_LDY: y = nz(opnd);
            OP_NOP: ;
            OP_PHA, OP_PHP: begin
               stk = 1'b1;
               wr  = 1'b1;
               saddr = {STACK_PAGE, s};
               wdata = p;
               wdata[FLAG_B] = 1'b1;
               wdata[FLAG_1] = 1'b1;
               if (func == OP_PHA) begin
                  wdata = a;
               end
               s = s - 8'h01;
            end
            OP_PLA, OP_PLP: begin
               stk = 1'b1;
               s = s + 8'h01;
               saddr = {STACK_PAGE, s};
               if (func == OP_PLA) begin
                  a = nz(opnd);
               end else begin
                  p = opnd;
                  p[FLAG_B] = 1'b0;
                  p[FLAG_1] = 1'b1;
               end
            end
            OP_STA: begin
               wr = 1'b1;
               wdata = a;
            end
            OP_STX: begin
               wr = 1'b1;
               wdata = x;
            end
            OP_STY: begin
               wr = 1'b1;
               wdata = y;
            end
            OP_TAX: x = nz(a);
            OP_TAY: y = nz(a);
            OP_TSX: x = nz(s);
            OP_TXA: a = nz(x);
            OP_TXS: s = x;
            OP_TYA: a = nz(y);
            default: unk = 1'b1;
         endcase

         if (rmw) begin
            case (tgt)
               TGT_A: a = res;
               TGT_X: x = res;
               TGT_Y: y = res;
               default: begin
                  wr = 1'b1;
                  wdata = res;
               end
            endcase
         end
         if (!stk) begin
            saddr = {STACK_PAGE, s};
         end

         r.mem_data     = wr ? wdata : 8'h00;
         r.mem_write    = wr;
         r.stack_addr   = saddr;
         r.out_a        = a;
         r.out_x        = x;
         r.out_y        = y;
         r.out_s        = s;
         r.out_p        = p;
         r.branch_taken = taken;
         r.unknown_op   = unk;
         expected_rsp.push_back(r);
      endfunction

      function void check_field(string name, logic [8:0] want, logic [8:0] got);
         if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
         end
      endfunction

      // Compare one accepted response with the oldest prediction
      function void check_response(logic [63:0] data);
         rsp_type got, want;
         got = data[59:0];
         if (expected_rsp.size() == 0) begin
            $error("response %h arrived with no request outstanding", data);
            errors++;
            return;
         end
         want = expected_rsp.pop_front();
         check_field("mem_data",     want.mem_data,     got.mem_data);
         check_field("mem_write",    want.mem_write,    got.mem_write);
         check_field("stack_addr",   want.stack_addr,   got.stack_addr);
         check_field("out_a",        want.out_a,        got.out_a);
         check_field("out_x",        want.out_x,        got.out_x);
         check_field("out_y",        want.out_y,        got.out_y);
         check_field("out_s",        want.out_s,        got.out_s);
         check_field("out_p",        want.out_p,        got.out_p);
         check_field("branch_taken", want.branch_taken, got.branch_taken);
         check_field("unknown_op",   want.unknown_op,   got.unknown_op);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [5:0] func, [7:6] target, [15:8] operand
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [7:0] mem_data, [8] mem_write, [17:9] stack_addr,
                             // [25:18] out_a, [33:26] out_x, [41:34] out_y,
                             // [49:42] out_s, [57:50] out_p, [58] branch_taken,
                             // [59] unknown_op, [63:60] zero

   exec_shadow shadow = new();
   bit         idle_on;      // random idling on both sides while set
   int         quiet_cycles;

   mos6502_alu_register_execute_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   // Receiver: stall at random while idling is on, otherwise always take responses
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Monitor both channels at the edge; check the response before noting the request,
   // since a response always belongs to an earlier request
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            shadow.check_response(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            shadow.note_request(req_tdata);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Present one request, idling first at random, and hold it until accepted.
   // Returns in the step of the accepting edge with nothing assigned yet.
   task automatic send_request(logic [5:0] func, logic [1:0] tgt, logic [7:0] opnd);
      while (idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {opnd, tgt, func};
      do begin
         @(posedge clock);
      end while (!req_tready);
   endtask

   // Drop valid and hold until every predicted response has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (shadow.expected_rsp.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Mostly supported operations, some unknown codes, operands biased to the edges
   task automatic send_random();
      logic [5:0] func;
      logic [7:0] opnd;
      if ($urandom_range(9) == 0) begin
         func = 6'($urandom_range(LAST_UNKNOWN, FIRST_UNKNOWN));
      end else begin
         func = 6'($urandom_range(FIRST_UNKNOWN - 1, 0));
      end
      case ($urandom_range(7))
         0:       opnd = 8'h00;
         1:       opnd = 8'hFF;
         2:       opnd = 8'h80;
         3:       opnd = 8'h7F;
         default: opnd = 8'($urandom_range(255));
      endcase
      send_request(func, 2'($urandom_range(3)), opnd);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 16'h0000;
      idle_on     = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Loads at the extremes; target is ignored outside shifts, INC and DEC
      send_request(OP_LDA, TGT_X,   8'h00);
      send_request(OP_LDA, TGT_Y,   8'h80);
      // Carry out and signed overflow through zero, then positive overflow
      send_request(OP_ADC, TGT_MEM, 8'h80);
      send_request(OP_CLC, TGT_MEM, 8'h00);
      send_request(OP_LDA, TGT_MEM, 8'h7F);
      send_request(OP_ADC, TGT_MEM, 8'h01);
      send_request(OP_SEC, TGT_MEM, 8'h00);
      send_request(OP_SBC, TGT_MEM, 8'hFF);
      // Read-modify-write on X, Y, A and memory, with wrap
      send_request(OP_LDX, TGT_MEM, 8'hFF);
      send_request(OP_INC, TGT_X,   8'h00);
      send_request(OP_DEC, TGT_Y,   8'h00);
      send_request(OP_ROL, TGT_MEM, 8'hFF);
      send_request(OP_ROR, TGT_A,   8'h01);
      send_request(OP_LSR, TGT_MEM, 8'h01);
      send_request(OP_BIT, TGT_MEM, 8'hFF);
      send_request(OP_BEQ, TGT_MEM, 8'h00);
      // Status push sets B and bit 5; pull clears B and sets bit 5
      send_request(OP_PHP, TGT_MEM, 8'h00);
      send_request(OP_PLP, TGT_MEM, 8'hFF);
      send_request(OP_PLP, TGT_MEM, 8'h00);
      // Stack wrap in both directions (X is zero here)
      send_request(OP_TXS, TGT_MEM, 8'h00);
      send_request(OP_PHA, TGT_MEM, 8'h00);
      send_request(OP_PLA, TGT_MEM, 8'h80);
      // Decimal flag only; arithmetic stays binary
      send_request(OP_SED, TGT_MEM, 8'h00);
      send_request(OP_ADC, TGT_MEM, 8'h99);
      send_request(OP_STA, TGT_MEM, 8'h00);
      send_request(6'(LAST_UNKNOWN), TGT_Y, 8'hFF);

      // Sweep every code once with random content, then go random
      for (int f = 0; f <= LAST_UNKNOWN; f++) begin
         send_request(6'(f), 2'($urandom_range(3)), 8'($urandom_range(255)));
      end
      for (int i = 0; i < NUM_RANDOM; i++) begin
         idle_on = !(i >= CALM_FIRST && i < CALM_LAST);
         if (i == DRAIN_AT) begin
            drain_responses();
         end
         send_random();
      end

      drain_responses();
      repeat (PIPE_CYCLES) @(posedge clock);
      if (shadow.errors == 0 && shadow.expected_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
